FILE: rtl/pwu_pkg.sv
// Shared types and constants for the particle weight update block.
// No dependencies.
package pwu_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_DIFF = 2'd1,
    ACT_MEAN = 2'd2,
    ACT_WGT  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNIF,
    ST_DOT_RD,
    ST_DOT_MAC,
    ST_PROD,
    ST_CHK,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_DIV_WR,
    ST_MEAN_RD,
    ST_MEAN_MAC,
    ST_MEAN_OUT,
    ST_WGT_RD,
    ST_WGT_OUT,
    ST_STAT_OUT
  } state_e;

  localparam int unsigned MaxOut = 4;
  localparam logic [31:0] WMax = 32'h7FFF_FFFF;
  localparam logic [0:0] RegNoise = 1'b0;

endpackage

FILE: rtl/pwu_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pwu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/pwu_div.sv
// Restoring fractional divider: floor(p * 2^31 / s), one quotient bit per cycle.
// Depends on pwu_pkg.
module pwu_div
  import pwu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [64:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [63:0] den_q;
  logic [64:0] sh;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    sh    = {rem_q[63:0], 1'b0};
    done_o = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 6'd0;
      quo_d = '0;
      if (num_i >= den_i) begin
        rem_d = {1'b0, num_i - den_i};
        quo_d = 32'd1;
      end else begin
        rem_d = {1'b0, num_i};
      end
    end else if (run_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd30) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  // quotient may reach 2^31 only via the leading bit
  logic quo_ovf_q, quo_ovf_d;
  always_comb begin
    quo_ovf_d = quo_ovf_q;
    if (start_i) begin
      quo_ovf_d = 1'b0;
    end else if (run_q && quo_q[31]) begin
      quo_ovf_d = 1'b1;
    end
  end

  assign quot_o = (quo_ovf_q || quo_q[31]) ? WMax : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      cnt_q     <= '0;
      quo_ovf_q <= 1'b0;
    end else begin
      run_q     <= run_d;
      cnt_q     <= cnt_d;
      quo_ovf_q <= quo_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

endmodule

FILE: rtl/particle_weight_update_top.sv
// Top level of the particle weight update block: sequencer, memories, APB register.
// Depends on pwu_pkg, pwu_ram, pwu_div.
//
// Every accepted item keeps busy high until its work ends, and start is taken
// only while busy is low. After reset busy stays high while every weight is set
// to uniform. A load or diff item without last_component leaves busy low. A load
// with last_component holds busy through the weight reset sweep. A last diff item
// walks all particles with one shared multiplier, then renormalizes each weight
// through a one-bit-a-cycle divider; it skips the renormalization when the
// weight sum is zero. A mean read holds busy while it walks all particles for
// each component, and a weight read while it reads the one weight. Results come
// as one-cycle strobes on result_valid_o and cannot be stalled.
module particle_weight_update_top
  import pwu_pkg::*;
#(
  parameter int unsigned PARTICLES  = 256,
  parameter int unsigned OBJECTIVES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [7:0]         particle_index_i,
  input  logic [1:0]         objective_index_i,
  input  logic signed [15:0] coefficient_i,
  input  logic               answer_i,
  input  logic               last_component_i,
  output logic               result_valid_o,
  output logic signed [31:0] out_value_o,
  output logic [7:0]         out_index_o,
  output logic               status_o,
  output logic               last_result_o
);

  localparam int unsigned PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int unsigned OW = (OBJECTIVES > 1) ? $clog2(OBJECTIVES) : 1;
  localparam int unsigned PtDepth = PARTICLES * (1 << OW);
  localparam int unsigned PtAw = PW + OW;
  localparam int unsigned NMean = (OBJECTIVES < MaxOut) ? OBJECTIVES : MaxOut;
  localparam logic [31:0] Uniform = 32'(64'h8000_0000 / 64'(PARTICLES));

  logic [15:0] noise_q;
  assign pready = 1'b1;
  assign prdata = (paddr == {RegNoise, 1'b0}) ? {16'd0, noise_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
    end else if (psel && penable && pwrite && paddr == {RegNoise, 1'b0}) begin
      noise_q <= pwdata[15:0];
    end
  end

  state_e state_q, state_d;
  logic [PW:0] pi_q, pi_d;
  logic [OW:0] oi_q, oi_d;
  logic [2:0]  ph_q, ph_d;
  logic        ans_q, ans_d;
  logic [7:0]  ridx_q, ridx_d;
  logic signed [15:0] diff_q [OBJECTIVES];
  logic signed [47:0] acc_q, acc_d;
  logic [63:0] sum_q, sum_d;

  logic          pt_we;
  logic [PtAw-1:0] pt_addr;
  logic [15:0]   pt_wdata, pt_rdata;
  logic          wt_we;
  logic [PW-1:0] wt_addr;
  logic [31:0]   wt_wdata, wt_rdata;
  logic          pb_we;
  logic [63:0]   pb_wdata, pb_rdata;

  pwu_ram #(.Width(16), .Depth(PtDepth)) u_pt (
    .clk_i, .we_i(pt_we), .addr_i(pt_addr), .wdata_i(pt_wdata), .rdata_o(pt_rdata)
  );
  pwu_ram #(.Width(32), .Depth(PARTICLES)) u_wt (
    .clk_i, .we_i(wt_we), .addr_i(wt_addr), .wdata_i(wt_wdata), .rdata_o(wt_rdata)
  );
  pwu_ram #(.Width(64), .Depth(PARTICLES)) u_pb (
    .clk_i, .we_i(pb_we), .addr_i(wt_addr), .wdata_i(pb_wdata), .rdata_o(pb_rdata)
  );

  logic        div_start, div_done;
  logic [31:0] div_q;
  pwu_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(pb_rdata), .den_i(sum_q),
    .done_o(div_done), .quot_o(div_q)
  );

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] mul_p_q;
  always_ff @(posedge clk_i) begin
    mul_p_q <= 49'(mul_a) * 49'(mul_b);
  end

  logic in_fire, pi_ok, oi_ok, dot_pos, match;
  logic [16:0] fac;
  logic signed [47:0] rnd;
  logic signed [48:0] qv;
  assign in_fire = start && !busy;
  assign pi_ok = 9'(particle_index_i) < 9'(PARTICLES) || PARTICLES > 255;
  assign oi_ok = 3'(objective_index_i) < 3'(OBJECTIVES) || OBJECTIVES > 3;
  assign dot_pos = !acc_q[47];
  assign match = (dot_pos == ans_q);
  assign fac = match ? (17'h10000 - 17'(noise_q)) : 17'(noise_q);
  assign rnd = acc_q + 48'sh4000_0000;
  assign qv = 49'(rnd >>> 31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNIF;
      pi_q    <= '0;
      oi_q    <= '0;
      ph_q    <= '0;
      for (int k = 0; k < OBJECTIVES; k++) diff_q[k] <= '0;
    end else begin
      state_q <= state_d;
      pi_q    <= pi_d;
      oi_q    <= oi_d;
      ph_q    <= ph_d;
      if (in_fire && action_i == ACT_DIFF && oi_ok) begin
        diff_q[OW'(objective_index_i)] <= coefficient_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ans_q  <= ans_d;
    ridx_q <= ridx_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
  end

  always_comb begin
    state_d = state_q;
    pi_d = pi_q;
    oi_d = oi_q;
    ph_d = ph_q;
    ans_d = ans_q;
    ridx_d = ridx_q;
    acc_d = acc_q;
    sum_d = sum_q;
    busy = (state_q != ST_IDLE);
    pt_we = 1'b0;
    pt_addr = {pi_q[PW-1:0], oi_q[OW-1:0]};
    pt_wdata = coefficient_i;
    wt_we = 1'b0;
    wt_addr = pi_q[PW-1:0];
    wt_wdata = Uniform;
    pb_we = 1'b0;
    pb_wdata = 64'(mul_p_q[48:0]);
    div_start = 1'b0;
    mul_a = 18'($signed(pt_rdata));
    mul_b = 33'(diff_q[oi_q[OW-1:0]]);
    result_valid_o = 1'b0;
    out_value_o = '0;
    out_index_o = '0;
    status_o = 1'b0;
    last_result_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pi_d = '0;
          oi_d = '0;
          ph_d = '0;
          ans_d = answer_i;
          ridx_d = particle_index_i;
          acc_d = '0;
          sum_d = '0;
          case (action_i)
            ACT_LOAD: begin
              pt_addr = {PW'(particle_index_i), OW'(objective_index_i)};
              pt_we = pi_ok && oi_ok;
              if (last_component_i) state_d = ST_UNIF;
            end
            ACT_DIFF: if (last_component_i) state_d = ST_DOT_RD;
            ACT_MEAN: state_d = ST_MEAN_RD;
            default:  state_d = ST_WGT_RD;
          endcase
        end
      end
      ST_UNIF: begin
        wt_we = 1'b1;
        pi_d = pi_q + (PW+1)'(1);
        if (pi_q == (PW+1)'(PARTICLES - 1)) state_d = ST_IDLE;
      end
      ST_DOT_RD: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin
          ph_d = '0;
          state_d = ST_DOT_MAC;
        end
      end
      ST_DOT_MAC: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin
          acc_d = acc_q + 48'(mul_p_q);
          ph_d = '0;
          oi_d = oi_q + (OW+1)'(1);
          if (oi_q == (OW+1)'(OBJECTIVES - 1)) begin
            oi_d = '0;
            state_d = ST_PROD;
          end else begin
            state_d = ST_DOT_RD;
          end
        end
      end
      ST_PROD: begin
        mul_a = $signed({1'b0, fac});
        mul_b = $signed({1'b0, wt_rdata});
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd2) begin
          pb_wdata = 64'(mul_p_q[47:0]);
          pb_we = 1'b1;
          sum_d = sum_q + pb_wdata;
          acc_d = '0;
          ph_d = '0;
          pi_d = pi_q + (PW+1)'(1);
          if (pi_q == (PW+1)'(PARTICLES - 1)) begin
            pi_d = '0;
            state_d = ST_CHK;
          end else begin
            state_d = ST_DOT_RD;
          end
        end
      end
      ST_CHK: begin
        if (sum_q == 64'd0) begin
          state_d = ST_STAT_OUT;
        end else begin
          state_d = ST_DIV_RD;
        end
      end
      ST_DIV_RD: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin
          ph_d = '0;
          div_start = 1'b1;
          state_d = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (div_done) state_d = ST_DIV_WR;
      end
      ST_DIV_WR: begin
        wt_we = 1'b1;
        wt_wdata = div_q;
        pi_d = pi_q + (PW+1)'(1);
        if (pi_q == (PW+1)'(PARTICLES - 1)) begin
          pi_d = '0;
          state_d = ST_STAT_OUT;
        end else begin
          state_d = ST_DIV_RD;
        end
      end
      ST_STAT_OUT: begin
        result_valid_o = 1'b1;
        status_o = (sum_q == 64'd0);
        last_result_o = 1'b1;
        state_d = ST_IDLE;
      end
      ST_MEAN_RD: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin
          ph_d = '0;
          state_d = ST_MEAN_MAC;
        end
      end
      ST_MEAN_MAC: begin
        mul_b = $signed({1'b0, wt_rdata});
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin
          acc_d = acc_q + 48'(mul_p_q);
          ph_d = '0;
          pi_d = pi_q + (PW+1)'(1);
          if (pi_q == (PW+1)'(PARTICLES - 1)) begin
            pi_d = '0;
            state_d = ST_MEAN_OUT;
          end else begin
            state_d = ST_MEAN_RD;
          end
        end
      end
      ST_MEAN_OUT: begin
        result_valid_o = 1'b1;
        out_value_o = 32'(qv);
        out_index_o = 8'(oi_q);
        last_result_o = (oi_q == (OW+1)'(NMean - 1));
        acc_d = '0;
        oi_d = oi_q + (OW+1)'(1);
        state_d = last_result_o ? ST_IDLE : ST_MEAN_RD;
      end
      ST_WGT_RD: begin
        wt_addr = PW'(ridx_q);
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) state_d = ST_WGT_OUT;
      end
      ST_WGT_OUT: begin
        result_valid_o = 1'b1;
        out_index_o = ridx_q;
        out_value_o = (9'(ridx_q) < 9'(PARTICLES) || PARTICLES > 255) ? wt_rdata : 32'd0;
        last_result_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/pwu_checker.sv
// Port-level checker for the particle weight update block, bound to the top.
// Depends on particle_weight_update_top.
module pwu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic status_o,
  input logic last_result_o,
  input logic [31:0] out_value_o
);

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");
  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> (out_value_o == 32'd0 && last_result_o))
    else $error("bad status result");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> !busy) else $error("busy after last");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> (!last_result_o && !status_o)) else $error("stray flags");

endmodule

bind particle_weight_update_top pwu_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .status_o, .last_result_o,
  .out_value_o
);

FILE: tb/testbench.sv
// Testbench for particle_weight_update_top: a scoreboard class predicts every
// result, and plain tasks drive the command and APB ports.
// Depends on pwu_pkg and the RTL of particle_weight_update_top.
`timescale 1ns / 100ps

module testbench;
  import pwu_pkg::*;

  localparam int unsigned NumParticles  = 256;
  localparam int unsigned NumObjectives = 4;
  localparam int unsigned RandomItems   = 470;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         index;
    logic               status;
    logic               last;
  } result_t;

  class weight_scoreboard;
    logic signed [15:0] coef_tab[NumParticles*NumObjectives];
    logic [31:0]        wgt_tab[NumParticles];
    logic signed [15:0] diff_vec[NumObjectives];
    logic [15:0]        noise;
    result_t            pending[$];
    int                 errors;

    function new();
      noise = '0;
      errors = 0;
      foreach (coef_tab[i]) coef_tab[i] = '0;
      foreach (diff_vec[i]) diff_vec[i] = '0;
      set_uniform();
    endfunction

    function void set_uniform();
      foreach (wgt_tab[i]) wgt_tab[i] = 32'h8000_0000 / NumParticles;
    endfunction

    function void push(logic signed [31:0] value, logic [7:0] index, logic st, logic last);
      result_t r;
      r.value = value;
      r.index = index;
      r.status = st;
      r.last = last;
      pending.push_back(r);
    endfunction

    function logic reweight(logic ans);
      logic [63:0] prod[NumParticles];
      logic [63:0] sum;
      logic [95:0] quot;
      longint      dot;
      logic        match;
      sum = '0;
      for (int i = 0; i < NumParticles; i++) begin
        dot = 0;
        for (int o = 0; o < NumObjectives; o++)
          dot += longint'(coef_tab[i*NumObjectives+o]) * longint'(diff_vec[o]);
        match = (dot >= 0) == ans;
        prod[i] = 64'(wgt_tab[i]) * (match ? 64'(65536 - noise) : 64'(noise));
        sum += prod[i];
      end
      if (sum == 0) return 1'b1;
      for (int i = 0; i < NumParticles; i++) begin
        quot = ({32'd0, prod[i]} << 31) / {32'd0, sum};
        wgt_tab[i] = (quot > 96'(WMax)) ? WMax : quot[31:0];
      end
      return 1'b0;
    endfunction

    function logic signed [31:0] mean_of(int o);
      longint acc;
      acc = 0;
      for (int i = 0; i < NumParticles; i++)
        acc += longint'(coef_tab[i*NumObjectives+o]) * longint'(wgt_tab[i]);
      acc += longint'(1) <<< 30;
      acc = acc >>> 31;
      return acc[31:0];
    endfunction

    function void note_item(action_e act, logic [7:0] pidx, logic [1:0] oidx,
                            logic signed [15:0] coef, logic ans, logic last);
      int n;
      case (act)
        ACT_LOAD: begin
          if (pidx < NumParticles && oidx < NumObjectives)
            coef_tab[pidx*NumObjectives+oidx] = coef;
          if (last) set_uniform();
        end
        ACT_DIFF: begin
          if (oidx < NumObjectives) diff_vec[oidx] = coef;
          if (last) push('0, '0, reweight(ans), 1'b1);
        end
        ACT_MEAN: begin
          n = (NumObjectives < MaxOut) ? NumObjectives : MaxOut;
          for (int k = 0; k < n; k++) push(mean_of(k), 8'(k), 1'b0, k == n - 1);
        end
        default: begin
          if (pidx < NumParticles) push(wgt_tab[pidx], pidx, 1'b0, 1'b1);
          else push('0, pidx, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result value %0d index %0d", got.value, got.index);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.value !== exp_r.value) begin
        $error("out_value: expected %0d, got %0d", exp_r.value, got.value);
        errors++;
      end
      if (got.index !== exp_r.index) begin
        $error("out_index: expected %0d, got %0d", exp_r.index, got.index);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_result: expected %0d, got %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [1:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               start, busy;
  logic [1:0]         action_i;
  logic [7:0]         particle_index_i;
  logic [1:0]         objective_index_i;
  logic signed [15:0] coefficient_i;
  logic               answer_i, last_component_i;
  logic               result_valid_o;
  logic signed [31:0] out_value_o;
  logic [7:0]         out_index_o;
  logic               status_o, last_result_o;

  weight_scoreboard sb = new();
  int               idle_pct;
  int               sent;

  particle_weight_update_top #(
    .PARTICLES (NumParticles),
    .OBJECTIVES(NumObjectives)
  ) uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (result_valid_o === 1'b1)
      sb.check_result({out_value_o, out_index_o, status_o, last_result_o});
  end

  // Hold start high until the transfer completes, then note it.
  task automatic send_item(action_e act, logic [7:0] pidx, logic [1:0] oidx,
                           logic signed [15:0] coef, logic ans, logic last);
    start <= 1'b1;
    action_i <= act;
    particle_index_i <= pidx;
    objective_index_i <= oidx;
    coefficient_i <= coef;
    answer_i <= ans;
    last_component_i <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(act, pidx, oidx, coef, ans, last);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_noise(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(RegNoise << 2);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.noise = value;
    @(posedge clk_i);
  endtask

  task automatic diff_vector(logic ans);
    int n;
    n = $urandom_range(1, NumObjectives);
    for (int k = 0; k < n; k++)
      send_item(ACT_DIFF, 8'($urandom), 2'(k), 16'($urandom), ans, k == n - 1);
  endtask

  task automatic random_items(int count);
    int stop_at;
    int pick;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30)
        send_item(ACT_LOAD, 8'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                  $urandom_range(19) == 0);
      else if (pick < 41)
        diff_vector(1'($urandom));
      else if (pick < 45)
        send_item(ACT_DIFF, 8'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                  $urandom_range(3) == 0);
      else if (pick < 53)
        send_item(ACT_MEAN, 8'($urandom), 2'($urandom), 16'($urandom), 1'($urandom), 1'b0);
      else
        send_item(ACT_WGT, 8'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    action_i = ACT_LOAD;
    particle_index_i = '0;
    objective_index_i = '0;
    coefficient_i = '0;
    answer_i = 1'b0;
    last_component_i = 1'b0;
    idle_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole coefficient table before anything reads it.
    for (int i = 0; i < NumParticles * NumObjectives; i++)
      send_item(ACT_LOAD, 8'(i / NumObjectives), 2'(i % NumObjectives),
                (i < 4) ? 16'sh8000 : (i < 8) ? 16'sh7FFF : 16'($urandom),
                1'($urandom), i == NumParticles * NumObjectives - 1);
    sent = 0;

    send_item(ACT_WGT, 8'd0, 2'd0, 16'sd0, 1'b0, 1'b0);
    send_item(ACT_WGT, 8'd255, 2'd3, 16'sh7FFF, 1'b1, 1'b1);
    send_item(ACT_MEAN, 8'd0, 2'd0, 16'sd0, 1'b0, 1'b0);
    send_item(ACT_DIFF, 8'd0, 2'd0, 16'sh8000, 1'b0, 1'b0);
    send_item(ACT_DIFF, 8'd255, 2'd1, 16'sh7FFF, 1'b0, 1'b0);
    send_item(ACT_DIFF, 8'd0, 2'd2, 16'sd0, 1'b0, 1'b0);
    send_item(ACT_DIFF, 8'd0, 2'd3, 16'sh1000, 1'b1, 1'b1);
    send_item(ACT_WGT, 8'd7, 2'd0, 16'sd0, 1'b0, 1'b0);
    send_item(ACT_DIFF, 8'd0, 2'd3, 16'shF000, 1'b0, 1'b1);
    send_item(ACT_DIFF, 8'd0, 2'd3, 16'shF000, 1'b1, 1'b1);
    send_item(ACT_MEAN, 8'd0, 2'd0, 16'sd0, 1'b0, 1'b0);
    send_item(ACT_LOAD, 8'd255, 2'd3, 16'sh7FFF, 1'b0, 1'b1);
    send_item(ACT_WGT, 8'd255, 2'd0, 16'sd0, 1'b0, 1'b0);
    drain();

    write_noise(16'd32768);
    idle_pct = 55;
    diff_vector(1'b1);
    send_item(ACT_MEAN, 8'd0, 2'd0, 16'sd0, 1'b0, 1'b0);
    random_items(RandomItems / 4);
    drain();

    write_noise(16'($urandom_range(1, 32767)));
    idle_pct = 55;
    random_items(RandomItems / 4);
    drain();

    write_noise(16'd1);
    idle_pct = 15;
    random_items(RandomItems / 4);
    drain();

    write_noise(16'd0);
    idle_pct = 0;
    random_items(RandomItems / 4);
    drain();

    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pwu_pkg.sv
rtl/pwu_ram.sv
rtl/pwu_div.sv
rtl/particle_weight_update_top.sv
rtl/pwu_checker.sv
tb/testbench.sv
